/* rtl/ppd_pkg.sv */
`timescale 1ns / 1ps

package ppd_pkg;

  // Number of receiver channels in one frame.
  localparam int NUM_CHANNELS = 8;
  // Width of a channel index and of the slot counter, which may reach NUM_CHANNELS.
  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SLOT_W = $clog2(NUM_CHANNELS + 1);
  // An accepted interval never exceeds max_width + tolerance, so 17 bits hold it.
  localparam int RAW_W  = 17;
  // Frames that may be missed before the input is declared lost.
  localparam int TIMEOUT_FRAMES = 3;
  localparam int LIMIT_W = 18;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_TIMEOUT = 3'd4;

  typedef struct packed {
    logic [15:0] min_width;
    logic [15:0] max_width;
    logic [15:0] tolerance;
    logic [15:0] frame_gap;
    logic [15:0] loss_timeout;
  } cfg_t;

  // One classified item on its way from the front to the back. For an edge the
  // data field holds the interval since the previous edge, for a poll the time.
  typedef struct packed {
    logic        is_poll;
    logic        gap;
    logic        in_range;
    logic [31:0] data;
  } cmd_t;

  function automatic logic [RAW_W-1:0] lower_bound(input cfg_t c);
    if (c.min_width > c.tolerance) begin
      return RAW_W'(c.min_width - c.tolerance);
    end
    return '0;
  endfunction

  function automatic logic [RAW_W-1:0] upper_bound(input cfg_t c);
    return RAW_W'(c.max_width) + RAW_W'(c.tolerance);
  endfunction

  // Truncate rule applied to a stored interval when a frame is taken.
  function automatic logic [15:0] clamp_width(input logic [RAW_W-1:0] r, input cfg_t c);
    logic [RAW_W-1:0] lo;
    logic [RAW_W-1:0] hi;
    lo = lower_bound(c);
    hi = upper_bound(c);
    priority if (r == '0) begin
      return '0;
    end else if (r < lo) begin
      return '0;
    end else if (r < RAW_W'(c.min_width)) begin
      return c.min_width;
    end else if (r <= RAW_W'(c.max_width)) begin
      return r[15:0];
    end else if (r < hi) begin
      return c.max_width;
    end else begin
      return '0;
    end
  endfunction

endpackage

/* rtl/ppd_front.sv */
`timescale 1ns / 1ps

module ppd_front import ppd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_push,
  input  logic        in_req_type,
  input  logic [31:0] in_edge_time,
  input  logic [31:0] in_now_ms,
  output logic        in_full,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [31:0]      prior_edge_r;
  logic [31:0]      pulse;
  logic [RAW_W-1:0] lo;
  logic [RAW_W-1:0] hi;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  assign pulse = in_edge_time - prior_edge_r;
  assign lo    = lower_bound(cfg);
  assign hi    = upper_bound(cfg);

  always_comb begin
    q_cmd.is_poll  = in_req_type;
    q_cmd.gap      = pulse > 32'(cfg.frame_gap);
    q_cmd.in_range = (pulse <= 32'(hi)) && (pulse >= 32'(lo));
    q_cmd.data     = in_req_type ? in_now_ms : pulse;
  end

  // The previous edge time is kept here so that the interval is known on entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_edge_r <= '0;
    end else if (q_push && !in_req_type) begin
      prior_edge_r <= in_edge_time;
    end
  end

endmodule

/* rtl/ppd_queue.sv */
`timescale 1ns / 1ps

module ppd_queue import ppd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t       head_r;
  cmd_t       tail_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign dout    = head_r;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

  // A push alongside a pop can only happen with one entry held, since the
  // queue refuses pushes when full; the new item then goes straight to the head.
  always_ff @(posedge clk) begin
    if (do_pop) begin
      if (do_push && count_r == 2'd1) begin
        head_r <= din;
      end else begin
        head_r <= tail_r;
      end
    end else if (do_push) begin
      if (count_r == 2'd0) begin
        head_r <= din;
      end else begin
        tail_r <= din;
      end
    end
  end

endmodule

/* rtl/ppd_back.sv */
`timescale 1ns / 1ps

module ppd_back import ppd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_channel,
  output logic [15:0] out_width,
  output logic        out_lost,
  output logic        out_fresh,
  output logic        out_last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              state_r;
  logic [SLOT_W-1:0] slot_r;
  logic              in_sync_r;
  logic [RAW_W-1:0]  raw_r [NUM_CHANNELS];
  logic              frame_ready_r;
  logic [15:0]       held_r [NUM_CHANNELS];
  logic              lost_r;
  logic [31:0]       last_frame_ms_r;
  logic [CH_W-1:0]   ch_r;
  logic              take_r;
  logic              clear_r;

  logic              out_valid_r;
  logic [3:0]        out_channel_r;
  logic [15:0]       out_width_r;
  logic              out_lost_r;
  logic              out_fresh_r;
  logic              out_last_r;

  logic              exec_edge;
  logic              exec_poll;
  logic              store;
  logic [SLOT_W-1:0] slot_inc;
  logic [SLOT_W-1:0] slot_after;
  logic [31:0]       base_ms;
  logic [31:0]       elapsed;
  logic [LIMIT_W-1:0] limit;
  logic              lost_base;
  logic              timeout;
  logic              emit;
  logic              ch_last;
  logic [15:0]       width_sel;

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign exec_edge = q_pop && !q_cmd.is_poll;
  assign exec_poll = q_pop && q_cmd.is_poll;

  assign store      = in_sync_r && !q_cmd.gap && q_cmd.in_range &&
                      (slot_r < SLOT_W'(NUM_CHANNELS));
  assign slot_inc   = slot_r + SLOT_W'(1);
  assign slot_after = store ? slot_inc : slot_r;

  // A taken frame restarts the loss timer at the poll's own time.
  assign base_ms   = frame_ready_r ? q_cmd.data : last_frame_ms_r;
  assign lost_base = frame_ready_r ? 1'b0 : lost_r;
  assign elapsed   = q_cmd.data - base_ms;
  assign limit     = LIMIT_W'(cfg.loss_timeout) * LIMIT_W'(TIMEOUT_FRAMES);
  assign timeout   = !lost_base && (elapsed >= 32'(limit));

  assign emit      = (state_r == ST_EMIT) && (!out_valid_r || out_pop);
  assign ch_last   = ch_r == CH_W'(NUM_CHANNELS - 1);
  assign width_sel = take_r ? clamp_width(raw_r[ch_r], cfg) : held_r[ch_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      slot_r          <= '0;
      in_sync_r       <= 1'b0;
      frame_ready_r   <= 1'b0;
      lost_r          <= 1'b1;
      last_frame_ms_r <= '0;
      ch_r            <= '0;
      take_r          <= 1'b0;
      clear_r         <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        raw_r[i]  <= '0;
        held_r[i] <= '0;
      end
    end else begin
      if (exec_edge) begin
        if (q_cmd.gap) begin
          slot_r    <= '0;
          in_sync_r <= 1'b1;
        end else if (in_sync_r) begin
          if (store) begin
            raw_r[slot_r[CH_W-1:0]] <= q_cmd.data[RAW_W-1:0];
            slot_r                  <= slot_inc;
          end else begin
            in_sync_r <= 1'b0;
          end
          if (slot_after >= SLOT_W'(NUM_CHANNELS)) begin
            frame_ready_r <= 1'b1;
            in_sync_r     <= 1'b0;
          end
        end
      end

      if (exec_poll) begin
        frame_ready_r <= 1'b0;
        lost_r        <= lost_base || timeout;
        take_r        <= frame_ready_r;
        clear_r       <= timeout;
        ch_r          <= '0;
        state_r       <= ST_EMIT;
        if (frame_ready_r) begin
          last_frame_ms_r <= q_cmd.data;
        end
      end

      if (emit) begin
        held_r[ch_r] <= width_sel;
        ch_r         <= ch_r + CH_W'(1);
        if (ch_last) begin
          state_r <= ST_IDLE;
          if (clear_r) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              raw_r[i] <= '0;
            end
          end
        end
      end
    end
  end

  // Output register: while emitting, reloaded in the cycle it is popped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_channel_r <= 4'(ch_r);
      out_width_r   <= width_sel;
      out_lost_r    <= lost_r;
      out_fresh_r   <= take_r;
      out_last_r    <= ch_last;
    end
  end

  assign out_empty   = !out_valid_r;
  assign out_channel = out_channel_r;
  assign out_width   = out_width_r;
  assign out_lost    = out_lost_r;
  assign out_fresh   = out_fresh_r;
  assign out_last    = out_last_r;

endmodule

/* rtl/ppm_pulse_train_decoder.sv */
// PPM pulse train decoder.
// Input channel: an item is transferred when in_push is high and in_full is low.
// in_req_type 0 marks a rising edge (in_edge_time is the timer value), 1 marks a
// poll (in_now_ms is the millisecond time). Edges produce no results; each poll
// produces one result per channel, channel 0 first, with out_last on the final one.
// Result channel: the oldest result sits on the out_ ports while out_empty is low
// and is transferred when out_pop is also high.
// Configuration: cfg_ready is always high; a transfer writes cfg_data to the
// register selected by cfg_index, and writes to unused indices are ignored.
// Timing: the front computes the edge interval and its range checks on entry and
// places the item in a two-entry queue. The back retires one edge a cycle while
// idle. A poll takes a decision step, then one channel a cycle through a single
// clamp unit while results are popped as they appear; the back takes no new item
// until the poll's last channel is emitted. The first result reaches the out_
// ports through the queue, the back's state register and the output register.
// A stalled receiver freezes the back on its current result; the queue keeps
// taking items until both entries are held, then in_full rises.
// Reset (rst_n low at a clock edge) restores the default configuration, clears
// all widths, marks the input as lost and empties the queue and output register.
`timescale 1ns / 1ps

module ppm_pulse_train_decoder import ppd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_req_type,
  input  logic [31:0]          in_edge_time,
  input  logic [31:0]          in_now_ms,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [3:0]           out_channel,
  output logic [15:0]          out_width,
  output logic                 out_lost,
  output logic                 out_fresh,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t cfg_r;
  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_empty;
  logic q_pop;
  cmd_t q_head;

  // Configuration registers: always ready; change only while idle (unenforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_width    <= 16'd1000;
      cfg_r.max_width    <= 16'd2000;
      cfg_r.tolerance    <= 16'd100;
      cfg_r.frame_gap    <= 16'd4000;
      cfg_r.loss_timeout <= 16'd60;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_WIDTH:    cfg_r.min_width    <= cfg_data;
        REG_MAX_WIDTH:    cfg_r.max_width    <= cfg_data;
        REG_TOLERANCE:    cfg_r.tolerance    <= cfg_data;
        REG_FRAME_GAP:    cfg_r.frame_gap    <= cfg_data;
        REG_LOSS_TIMEOUT: cfg_r.loss_timeout <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: takes items in and classifies edges against the timing windows.
  ppd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_push      (in_push),
    .in_req_type  (in_req_type),
    .in_edge_time (in_edge_time),
    .in_now_ms    (in_now_ms),
    .in_full      (in_full),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_in)
  );

  // Short queue that lets the front keep accepting while the back is busy.
  ppd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  // Back: frame state, clamping of a taken frame and the per-channel results.
  ppd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_empty     (q_empty),
    .q_cmd       (q_head),
    .q_pop       (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_channel (out_channel),
    .out_width   (out_width),
    .out_lost    (out_lost),
    .out_fresh   (out_fresh),
    .out_last    (out_last)
  );

`ifndef NO_ASSERTIONS
  // The final result of a poll always reports the highest channel.
  a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last) |-> (out_channel == 4'(NUM_CHANNELS - 1)))
    else $error("last flag on a channel other than the highest");

  // Within a poll, the next channel follows directly after each transfer.
  a_channel_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last) |=>
      (!out_empty && out_channel == 4'($past(out_channel) + 4'd1)))
    else $error("poll results not delivered in consecutive channel order");

  // A fresh frame always clears the lost flag unless the timeout is zero.
  a_fresh_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_fresh && cfg_r.loss_timeout != 16'd0) |-> !out_lost)
    else $error("fresh frame reported as lost with a nonzero timeout");
`endif

endmodule
